// ----- src/usm_pkg.sv -----
// Shared types, constants and helper functions for the UV sphere mesh generator.
// No dependencies; every other file in src imports this package.
package usm_pkg;

    // Counter and divider widths
    localparam int CNT_W = 8;
    localparam int DIV_W = 26;
    localparam int DSR_W = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_SLICES = 2'd1;
    localparam logic [1:0] REG_STACKS = 2'd2;

    // Element kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI    = 1'b1;

    // Quarter turn, also 1.0 in Q1.14
    localparam logic [15:0] QUARTER = 16'd16384;

    // Odd polynomial for sin(pi/2*x), Q30
    localparam logic [31:0] C1 = 32'd1686629713;
    localparam logic [31:0] C3 = 32'd693598669;
    localparam logic [31:0] C5 = 32'd85569306;
    localparam logic [31:0] C7 = 32'd5026990;
    localparam logic [31:0] C9 = 32'd172272;

    typedef enum logic [2:0] {
        PH_TOP,
        PH_RING,
        PH_BOT,
        PH_CAP_TOP,
        PH_INNER,
        PH_CAP_BOT
    } phase_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CALC,
        T_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_DIV,
        E_SIN,
        E_PROD
    } eng_state_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
    } vtx_t;

    typedef struct packed {
        logic        kind;
        vtx_t        v;
        logic [12:0] corner_a;
        logic [12:0] corner_b;
        logic [12:0] corner_c;
    } elem_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] ring;
        logic [CNT_W-1:0] slice;
        logic [6:0]       ns;
        logic [6:0]       nk;
    } eng_req_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    // Horner coefficient for step 1..4
    function automatic logic [31:0] horner_coef(input logic [2:0] step);
        logic [31:0] c;
        case (step)
            3'd1:    c = C7;
            3'd2:    c = C5;
            3'd3:    c = C3;
            default: c = C1;
        endcase
        return c;
    endfunction

    // Arithmetic right shift rounded half away from zero
    function automatic logic signed [65:0] round_shift(input logic signed [65:0] v,
                                                       input int n);
        logic               neg;
        logic signed [65:0] m;
        neg = v[65];
        m = neg ? -v : v;
        m = (m + (66'sd1 <<< (n - 1))) >>> n;
        return neg ? -m : m;
    endfunction

endpackage

// ----- src/usm_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on usm_pkg for widths and the request struct.
module usm_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  usm_pkg::div_req_t       req,
    output logic                    done,
    output logic [usm_pkg::DIV_W-1:0] quot
);
    import usm_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W:0]   trial;

    // Load on start, else one restoring step while busy
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DIV_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DSR_W'(trial - {1'b0, dsr_reg});
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DSR_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = dvd_reg;

endmodule

// ----- src/usm_vertex.sv -----
// Ring vertex engine: three divisions on the divider, then four sine evaluations
// and the final products on one shared multiplier. Depends on usm_pkg and usm_div.
module usm_vertex (
    input  logic              clk,
    input  logic              rst_n,
    input  usm_pkg::eng_req_t req,
    input  logic [22:0]       radius,
    output logic              done,
    output usm_pkg::vtx_t     res
);
    import usm_pkg::*;

    eng_state_t         state_reg, state_next;
    logic [1:0]         idx_reg, idx_next;
    logic               issued_reg, issued_next;
    logic [2:0]         step_reg, step_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   ring_reg, ring_next;
    logic [CNT_W-1:0]   slice_reg, slice_next;
    logic [6:0]         ns_reg, ns_next;
    logic [6:0]         nk_reg, nk_next;
    logic [16:0]        thq_reg, thq_next;
    logic [15:0]        ph_reg, ph_next;
    logic [16:0]        tv_reg, tv_next;
    logic [30:0]        u2_reg, u2_next;
    logic [31:0]        p_reg, p_next;
    logic signed [15:0] sin_reg [4];
    logic signed [15:0] sin_val;
    logic               sin_we;
    logic signed [31:0] nxp_reg, nxp_next;
    logic signed [31:0] nzp_reg, nzp_next;
    logic signed [23:0] px_reg, px_next;
    logic signed [23:0] py_reg, py_next;
    logic signed [23:0] pz_reg, pz_next;

    div_req_t           dreq;
    logic               div_done;
    logic [DIV_W-1:0]   quot;

    logic [15:0]        ang;
    logic [1:0]         quad;
    logic [14:0]        xf;
    logic [30:0]        u;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [32:0]        rsum;
    logic [16:0]        rr;

    usm_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .done (div_done),
        .quot (quot)
    );

    // Angle folding for the current sine
    always_comb
    begin
        case (idx_reg)
            2'd0:    ang = ph_reg;
            2'd1:    ang = ph_reg + QUARTER;
            2'd2:    ang = thq_reg[15:0];
            default: ang = thq_reg[15:0] + QUARTER;
        endcase
        quad = ang[15:14];
        xf   = quad[0] ? 15'(QUARTER - {2'b00, ang[13:0]}) : {1'b0, ang[13:0]};
        u    = {xf, 16'b0};
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == E_SIN)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = $signed({2'b00, u});
                    mul_b = $signed({2'b00, u});
                end
                3'd5:
                begin
                    mul_a = $signed({2'b00, u});
                    mul_b = $signed({1'b0, p_reg});
                end
                default:
                begin
                    mul_a = $signed({2'b00, u2_reg});
                    mul_b = $signed({1'b0, p_reg});
                end
            endcase
        end
        else if (state_reg == E_PROD)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = 33'(sin_reg[0]);
                    mul_b = 33'(sin_reg[3]);
                end
                3'd1:
                begin
                    mul_a = 33'(sin_reg[0]);
                    mul_b = 33'(sin_reg[2]);
                end
                3'd2:
                begin
                    mul_a = $signed({10'b0, radius});
                    mul_b = 33'(nxp_reg);
                end
                3'd3:
                begin
                    mul_a = $signed({10'b0, radius});
                    mul_b = 33'(nzp_reg);
                end
                default:
                begin
                    mul_a = $signed({10'b0, radius});
                    mul_b = 33'(sin_reg[1]);
                end
            endcase
        end
    end

    assign prod = mul_a * mul_b;

    // Final sine rounding to Q1.14 with clamp and quadrant sign
    always_comb
    begin
        rsum = prod[62:30] + 33'd32768;
        rr   = (rsum[32:16] > 17'(QUARTER)) ? 17'(QUARTER) : rsum[32:16];
        sin_val = quad[1] ? -$signed(rr[15:0]) : $signed(rr[15:0]);
    end

    // Divider requests
    always_comb
    begin
        dreq.start = (state_reg == E_DIV) && !issued_reg;
        case (idx_reg)
            2'd0:
            begin
                dreq.dividend = (DIV_W'(slice_reg) << 17) + DIV_W'(ns_reg);
                dreq.divisor  = {ns_reg, 1'b0};
            end
            2'd1:
            begin
                dreq.dividend = (DIV_W'(ring_reg) << 16) + DIV_W'(nk_reg);
                dreq.divisor  = {nk_reg, 1'b0};
            end
            default:
            begin
                dreq.dividend = (DIV_W'(ring_reg) << 17) + DIV_W'(nk_reg);
                dreq.divisor  = {nk_reg, 1'b0};
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        issued_next = issued_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        ring_next   = ring_reg;
        slice_next  = slice_reg;
        ns_next     = ns_reg;
        nk_next     = nk_reg;
        thq_next    = thq_reg;
        ph_next     = ph_reg;
        tv_next     = tv_reg;
        u2_next     = u2_reg;
        p_next      = p_reg;
        sin_we      = 1'b0;
        nxp_next    = nxp_reg;
        nzp_next    = nzp_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        pz_next     = pz_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (req.start)
                begin
                    ring_next   = req.ring;
                    slice_next  = req.slice;
                    ns_next     = req.ns;
                    nk_next     = req.nk;
                    idx_next    = 2'd0;
                    issued_next = 1'b0;
                    state_next  = E_DIV;
                end
            end
            E_DIV:
            begin
                if (!issued_reg)
                begin
                    issued_next = 1'b1;
                end
                else if (div_done)
                begin
                    issued_next = 1'b0;
                    case (idx_reg)
                        2'd0:    thq_next = quot[16:0];
                        2'd1:    ph_next  = quot[15:0];
                        default: tv_next  = quot[16:0];
                    endcase
                    if (idx_reg == 2'd2)
                    begin
                        idx_next   = 2'd0;
                        step_next  = 3'd0;
                        state_next = E_SIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            E_SIN:
            begin
                case (step_reg)
                    3'd0:
                    begin
                        u2_next   = prod[60:30];
                        p_next    = C9;
                        step_next = 3'd1;
                    end
                    3'd5:
                    begin
                        sin_we    = 1'b1;
                        step_next = 3'd0;
                        if (idx_reg == 2'd3)
                        begin
                            state_next = E_PROD;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                        p_next    = horner_coef(step_reg) - prod[61:30];
                        step_next = step_reg + 3'd1;
                    end
                endcase
            end
            E_PROD:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:    nxp_next = prod[31:0];
                    3'd1:    nzp_next = prod[31:0];
                    3'd2:    px_next  = 24'(round_shift(prod, 28));
                    3'd3:    pz_next  = 24'(round_shift(prod, 28));
                    default:
                    begin
                        py_next    = 24'(round_shift(prod, 14));
                        done_next  = 1'b1;
                        step_next  = 3'd0;
                        state_next = E_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            idx_reg    <= 2'd0;
            issued_reg <= 1'b0;
            step_reg   <= 3'd0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            issued_reg <= issued_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ring_reg  <= ring_next;
        slice_reg <= slice_next;
        ns_reg    <= ns_next;
        nk_reg    <= nk_next;
        thq_reg   <= thq_next;
        ph_reg    <= ph_next;
        tv_reg    <= tv_next;
        u2_reg    <= u2_next;
        p_reg     <= p_next;
        nxp_reg   <= nxp_next;
        nzp_reg   <= nzp_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        if (sin_we)
        begin
            sin_reg[idx_reg] <= sin_val;
        end
    end

    // Result assembly; held until the next start
    always_comb
    begin
        res.pos_x  = px_reg;
        res.pos_y  = py_reg;
        res.pos_z  = pz_reg;
        res.norm_x = 16'(round_shift(66'(nxp_reg), 14));
        res.norm_y = sin_reg[1];
        res.norm_z = 16'(round_shift(66'(nzp_reg), 14));
        res.tex_u  = thq_reg;
        res.tex_v  = tv_reg;
    end

    assign done = done_reg;

endmodule

// ----- src/uv_sphere_mesh_generator.sv -----
// UV sphere mesh generator: one mesh element (vertex or triangle) per request.
// Poles and triangles are built in the accept cycle into the pending register
// and move on into the output register once it is free. A ring vertex takes
// three runs of the restoring divider (issue, 26 quotient steps, done), four
// sine polynomials at six passes each on the one shared multiplier, five
// product passes, and a hand-off through the pending register into the output
// register. The block is not ready while a vertex is in work or while a
// finished element waits for a full output register; a new request is taken
// while a finished element waits at the output.
// Depends on usm_pkg, usm_vertex and usm_div.
module uv_sphere_mesh_generator #(
    parameter int MAX_SLICES = 64,
    parameter int MAX_STACKS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic signed [23:0] pos_x,
    output logic signed [23:0] pos_y,
    output logic signed [23:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [12:0]        corner_a,
    output logic [12:0]        corner_b,
    output logic [12:0]        corner_c,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [22:0]        cfg_data
);
    import usm_pkg::*;

    top_state_t       state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] ring_reg, ring_next;
    logic [CNT_W-1:0] slice_reg, slice_next;
    logic             half_reg, half_next;
    logic [22:0]      radius_reg;
    logic [6:0]       slices_reg;
    logic [6:0]       stacks_reg;
    elem_t            pend_reg, pend_next;
    elem_t            out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             accept;
    logic             seq_rst;
    phase_t           ph_e;
    logic [CNT_W-1:0] ring_e, slice_e;
    logic             half_e;
    logic [6:0]       ns, nk;
    logic [7:0]       rv;
    logic [15:0]      south, base, top, low;
    logic [CNT_W:0]   slice_inc, ring_inc;
    eng_req_t         ereq;
    logic             eng_done;
    vtx_t             eng_res;

    // Saturated counts
    always_comb
    begin
        if (slices_reg < 7'd3)
            ns = 7'd3;
        else if (32'(slices_reg) > MAX_SLICES)
            ns = 7'(MAX_SLICES);
        else
            ns = slices_reg;
        if (stacks_reg < 7'd2)
            nk = 7'd2;
        else if (32'(stacks_reg) > MAX_STACKS)
            nk = 7'(MAX_STACKS);
        else
            nk = stacks_reg;
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == T_IDLE);
    assign seq_rst  = restart || (phase_reg > PH_CAP_BOT);

    // Effective sequence state after a restart
    always_comb
    begin
        ph_e    = seq_rst ? PH_TOP : phase_reg;
        ring_e  = seq_rst ? '0 : ring_reg;
        slice_e = seq_rst ? '0 : slice_reg;
        half_e  = seq_rst ? 1'b0 : half_reg;
        rv      = {1'b0, ns} + 8'd1;
        south   = 16'(({9'b0, nk} - 16'd1) * {8'b0, rv}) + 16'd1;
        base    = south - {8'b0, rv};
        top     = 16'd1 + 16'({8'b0, ring_e} * {8'b0, rv}) + {8'b0, slice_e};
        low     = top + {8'b0, rv};
        slice_inc = {1'b0, slice_e} + 1'b1;
        ring_inc  = {1'b0, ring_e} + 1'b1;
    end

    // Sequencer, element builder and output staging
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ring_next      = ring_reg;
        slice_next     = slice_reg;
        half_next      = half_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ereq.start     = 1'b0;
        ereq.ring      = ring_e;
        ereq.slice     = slice_e;
        ereq.ns        = ns;
        ereq.nk        = nk;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    phase_next = ph_e;
                    ring_next  = ring_e;
                    slice_next = slice_e;
                    half_next  = half_e;
                    pend_next  = '0;
                    state_next = T_HOLD;
                    case (ph_e)
                        PH_TOP:
                        begin
                            pend_next.kind     = KIND_VERTEX;
                            pend_next.v.pos_y  = $signed({1'b0, radius_reg});
                            pend_next.v.norm_y = $signed(QUARTER);
                            phase_next = PH_RING;
                            ring_next  = 8'd1;
                            slice_next = '0;
                        end
                        PH_RING:
                        begin
                            ereq.start = 1'b1;
                            state_next = T_CALC;
                            slice_next = slice_inc[CNT_W-1:0];
                            if (slice_inc > {2'b00, ns})
                            begin
                                slice_next = '0;
                                ring_next  = ring_inc[CNT_W-1:0];
                                if (ring_inc > {2'b00, nk} - 9'd1)
                                    phase_next = PH_BOT;
                            end
                        end
                        PH_BOT:
                        begin
                            pend_next.kind     = KIND_VERTEX;
                            pend_next.v.pos_y  = 24'sd0 - $signed({1'b0, radius_reg});
                            pend_next.v.norm_y = 16'sd0 - $signed(QUARTER);
                            pend_next.v.tex_v  = 17'd65536;
                            phase_next = PH_CAP_TOP;
                            ring_next  = '0;
                            slice_next = '0;
                        end
                        PH_CAP_TOP:
                        begin
                            pend_next.kind     = KIND_TRI;
                            pend_next.corner_a = 13'd0;
                            pend_next.corner_b = 13'({5'b0, slice_e} + 13'd2);
                            pend_next.corner_c = 13'({5'b0, slice_e} + 13'd1);
                            slice_next = slice_inc[CNT_W-1:0];
                            if (slice_inc >= {2'b00, ns})
                            begin
                                slice_next = '0;
                                ring_next  = '0;
                                half_next  = 1'b0;
                                phase_next = (nk > 7'd2) ? PH_INNER : PH_CAP_BOT;
                            end
                        end
                        PH_INNER:
                        begin
                            pend_next.kind = KIND_TRI;
                            if (!half_e)
                            begin
                                pend_next.corner_a = top[12:0];
                                pend_next.corner_b = 13'(top + 16'd1);
                                pend_next.corner_c = low[12:0];
                                half_next = 1'b1;
                            end
                            else
                            begin
                                pend_next.corner_a = low[12:0];
                                pend_next.corner_b = 13'(top + 16'd1);
                                pend_next.corner_c = 13'(low + 16'd1);
                                half_next  = 1'b0;
                                slice_next = slice_inc[CNT_W-1:0];
                                if (slice_inc >= {2'b00, ns})
                                begin
                                    slice_next = '0;
                                    ring_next  = ring_inc[CNT_W-1:0];
                                    if (ring_inc >= {2'b00, nk} - 9'd2)
                                    begin
                                        ring_next  = '0;
                                        phase_next = PH_CAP_BOT;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            pend_next.kind     = KIND_TRI;
                            pend_next.corner_a = south[12:0];
                            pend_next.corner_b = 13'(base + {8'b0, slice_e});
                            pend_next.corner_c = 13'(base + {8'b0, slice_e} + 16'd1);
                            slice_next = slice_inc[CNT_W-1:0];
                            if (slice_inc >= {2'b00, ns})
                            begin
                                slice_next = '0;
                                ring_next  = '0;
                                half_next  = 1'b0;
                                phase_next = PH_TOP;
                            end
                        end
                    endcase
                end
            end
            T_CALC:
            begin
                if (eng_done)
                begin
                    pend_next.kind = KIND_VERTEX;
                    pend_next.v    = eng_res;
                    state_next     = T_HOLD;
                end
            end
            T_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    usm_vertex u_vertex (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ereq),
        .radius(radius_reg),
        .done  (eng_done),
        .res   (eng_res)
    );

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 23'd65536;
            slices_reg <= 7'd8;
            stacks_reg <= 7'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data;
                REG_SLICES: slices_reg <= cfg_data[6:0];
                REG_STACKS: stacks_reg <= cfg_data[6:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            phase_reg     <= PH_TOP;
            ring_reg      <= '0;
            slice_reg     <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            ring_reg      <= ring_next;
            slice_reg     <= slice_next;
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // Output ports
    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign pos_x     = out_reg.v.pos_x;
    assign pos_y     = out_reg.v.pos_y;
    assign pos_z     = out_reg.v.pos_z;
    assign norm_x    = out_reg.v.norm_x;
    assign norm_y    = out_reg.v.norm_y;
    assign norm_z    = out_reg.v.norm_z;
    assign tex_u     = out_reg.v.tex_u;
    assign tex_v     = out_reg.v.tex_v;
    assign corner_a  = out_reg.corner_a;
    assign corner_b  = out_reg.corner_b;
    assign corner_c  = out_reg.corner_c;

endmodule

// ----- tb/usm_checker.sv -----
// Checker for the UV sphere mesh generator: watches the request, result and
// register channels, predicts each mesh element and compares field by field.
// Depends on usm_pkg.
module usm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               restart,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               kind,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [23:0] pos_z,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic [16:0]        tex_u,
    input  logic [16:0]        tex_v,
    input  logic [12:0]        corner_a,
    input  logic [12:0]        corner_b,
    input  logic [12:0]        corner_c,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);
    import usm_pkg::*;

    elem_t elem_q[$];

    // Model copy of registers and sequence counters
    logic [22:0] exp_radius;
    logic [6:0]  m_slices, m_stacks;
    logic [2:0]  m_phase;
    int          m_ring, m_slice;
    bit          m_half;

    assign pending = elem_q.size();

    // Sine of a quarter-wave fraction, Q1.14
    function automatic longint quarter_sine(input longint x);
        longint unsigned u, u2, p, r;
        u  = longint'(x) << 16;
        u2 = (u * u) >> 30;
        p  = 64'd172272;
        p  = 64'd5026990 - ((u2 * p) >> 30);
        p  = 64'd85569306 - ((u2 * p) >> 30);
        p  = 64'd693598669 - ((u2 * p) >> 30);
        p  = 64'd1686629713 - ((u2 * p) >> 30);
        r  = (u * p) >> 30;
        r  = (r + 32768) >> 16;
        if (r > 16384) r = 16384;
        return longint'(r);
    endfunction

    function automatic longint turn_sine(input longint a);
        longint q, x, r;
        a = a & 64'hFFFF;
        q = a >> 14;
        x = a & 64'h3FFF;
        if (q[0]) x = 16384 - x;
        r = quarter_sine(x);
        return q[1] ? -r : r;
    endfunction

    function automatic longint shift_round(input longint v, input int n);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (n - 1))) >>> n;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint div_round(input longint num, input longint den);
        return (num * 2 + den) / (den * 2);
    endfunction

    function automatic elem_t make_vertex(input longint px, py, pz, nx, ny, nz, tu, tv);
        elem_t e;
        e = '0;
        e.kind = KIND_VERTEX;
        e.v.pos_x = px[23:0];
        e.v.pos_y = py[23:0];
        e.v.pos_z = pz[23:0];
        e.v.norm_x = nx[15:0];
        e.v.norm_y = ny[15:0];
        e.v.norm_z = nz[15:0];
        e.v.tex_u = tu[16:0];
        e.v.tex_v = tv[16:0];
        return e;
    endfunction

    function automatic elem_t make_tri(input int a, b, c);
        elem_t e;
        e = '0;
        e.kind = KIND_TRI;
        e.corner_a = a[12:0];
        e.corner_b = b[12:0];
        e.corner_c = c[12:0];
        return e;
    endfunction

    // Advance the sequence by one request and return the element it yields
    function automatic elem_t next_element(input bit rs);
        int     ns, nk, rv, south, base, top, low;
        longint r, th, ph, sp, cp, st, ct;
        elem_t  e;
        ns = (m_slices < 3) ? 3 : (m_slices > 64) ? 64 : m_slices;
        nk = (m_stacks < 2) ? 2 : (m_stacks > 64) ? 64 : m_stacks;
        rv = ns + 1;
        south = (nk - 1) * rv + 1;
        base = south - rv;
        r = exp_radius;
        if (rs || m_phase > 5) begin
            m_phase = 0;
            m_ring = 0;
            m_slice = 0;
            m_half = 0;
        end
        case (m_phase)
            3'd0:
            begin
                e = make_vertex(0, r, 0, 0, 16384, 0, 0, 0);
                m_phase = 1;
                m_ring = 1;
                m_slice = 0;
            end
            3'd1:
            begin
                th = div_round(longint'(m_slice) * 65536, ns) & 64'hFFFF;
                ph = div_round(longint'(m_ring) * 32768, nk) & 64'hFFFF;
                sp = turn_sine(ph);
                cp = turn_sine(ph + 16384);
                st = turn_sine(th);
                ct = turn_sine(th + 16384);
                e = make_vertex(shift_round(r * sp * ct, 28), shift_round(r * cp, 14),
                                shift_round(r * sp * st, 28), shift_round(sp * ct, 14), cp,
                                shift_round(sp * st, 14),
                                div_round(longint'(m_slice) * 65536, ns),
                                div_round(longint'(m_ring) * 65536, nk));
                m_slice++;
                if (m_slice > ns) begin
                    m_slice = 0;
                    m_ring++;
                    if (m_ring > nk - 1) m_phase = 2;
                end
            end
            3'd2:
            begin
                e = make_vertex(0, -r, 0, 0, -16384, 0, 0, 65536);
                m_phase = 3;
                m_ring = 0;
                m_slice = 0;
            end
            3'd3:
            begin
                e = make_tri(0, m_slice + 2, m_slice + 1);
                m_slice++;
                if (m_slice >= ns) begin
                    m_slice = 0;
                    m_ring = 0;
                    m_half = 0;
                    m_phase = (nk > 2) ? 4 : 5;
                end
            end
            3'd4:
            begin
                top = 1 + m_ring * rv + m_slice;
                low = top + rv;
                if (!m_half) begin
                    e = make_tri(top, top + 1, low);
                    m_half = 1;
                end
                else begin
                    e = make_tri(low, top + 1, low + 1);
                    m_half = 0;
                    m_slice++;
                    if (m_slice >= ns) begin
                        m_slice = 0;
                        m_ring++;
                        if (m_ring >= nk - 2) begin
                            m_ring = 0;
                            m_phase = 5;
                        end
                    end
                end
            end
            default:
            begin
                e = make_tri(south, base + m_slice, base + m_slice + 1);
                m_slice++;
                if (m_slice >= ns) begin
                    m_slice = 0;
                    m_ring = 0;
                    m_half = 0;
                    m_phase = 0;
                end
            end
        endcase
        return e;
    endfunction

    // Track register writes, predict on accepted requests, compare results
    always @(posedge clk or negedge rst_n)
    begin
        elem_t x;
        if (!rst_n) begin
            exp_radius <= 23'd65536;
            m_slices <= 7'd8;
            m_stacks <= 7'd8;
            m_phase <= 0;
            m_ring <= 0;
            m_slice <= 0;
            m_half <= 0;
            fail_count <= 0;
            elem_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RADIUS: exp_radius = cfg_data;
                    REG_SLICES: m_slices = cfg_data[6:0];
                    REG_STACKS: m_stacks = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready) elem_q.insert(elem_q.size(), next_element(restart));
            if (out_valid && out_ready) begin
                if (elem_q.size() == 0) begin
                    $error("result with no request waiting");
                    fail_count <= fail_count + 1;
                end
                else begin
                    x = elem_q.pop_front();
                    if (kind !== x.kind ||
                        pos_x !== x.v.pos_x || pos_y !== x.v.pos_y ||
                        pos_z !== x.v.pos_z || norm_x !== x.v.norm_x ||
                        norm_y !== x.v.norm_y || norm_z !== x.v.norm_z ||
                        tex_u !== x.v.tex_u || tex_v !== x.v.tex_v ||
                        corner_a !== x.corner_a || corner_b !== x.corner_b ||
                        corner_c !== x.corner_c)
                        fail_count <= fail_count + 1;
                    if (kind !== x.kind) $error("kind exp %0d got %0d", x.kind, kind);
                    if (pos_x !== x.v.pos_x) $error("pos_x exp %0d got %0d", x.v.pos_x, pos_x);
                    if (pos_y !== x.v.pos_y) $error("pos_y exp %0d got %0d", x.v.pos_y, pos_y);
                    if (pos_z !== x.v.pos_z) $error("pos_z exp %0d got %0d", x.v.pos_z, pos_z);
                    if (norm_x !== x.v.norm_x)
                        $error("norm_x exp %0d got %0d", x.v.norm_x, norm_x);
                    if (norm_y !== x.v.norm_y)
                        $error("norm_y exp %0d got %0d", x.v.norm_y, norm_y);
                    if (norm_z !== x.v.norm_z)
                        $error("norm_z exp %0d got %0d", x.v.norm_z, norm_z);
                    if (tex_u !== x.v.tex_u) $error("tex_u exp %0d got %0d", x.v.tex_u, tex_u);
                    if (tex_v !== x.v.tex_v) $error("tex_v exp %0d got %0d", x.v.tex_v, tex_v);
                    if (corner_a !== x.corner_a)
                        $error("corner_a exp %0d got %0d", x.corner_a, corner_a);
                    if (corner_b !== x.corner_b)
                        $error("corner_b exp %0d got %0d", x.corner_b, corner_b);
                    if (corner_c !== x.corner_c)
                        $error("corner_c exp %0d got %0d", x.corner_c, corner_c);
                end
            end
        end
    end

endmodule

// ----- tb/tb_uv_sphere_mesh_generator.sv -----
// Top of the UV sphere mesh generator testbench: clock, reset, request and
// register stimulus, result stalls and the verdict. Depends on usm_pkg,
// usm_checker and the generator itself.
module tb_uv_sphere_mesh_generator;
    import usm_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               restart = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               kind;
    logic signed [23:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic [16:0]        tex_u, tex_v;
    logic [12:0]        corner_a, corner_b, corner_c;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = REG_RADIUS;
    logic [22:0]        cfg_data = '0;
    int                 fail_count, pending;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 quiet_cycles = 0;

    always #4 clk = ~clk;

    uv_sphere_mesh_generator i_dut (.*);

    usm_checker i_checker (.*);

    // Random result stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles with no accepted request of any kind
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Valid stays high past the accepting edge; the next step lowers it or
    // presents the next request, so each edge gets one assignment
    task automatic send_request(input bit rs);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart <= rs;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [22:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    // A run of n requests, with an occasional restart mixed in
    task automatic run_sequence(input int n, input int restart_pct);
        for (int k = 0; k < n; k++)
            send_request($urandom_range(99) < restart_pct);
    endtask

    initial
    begin
        int ns, nk, seq;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, restart at pole, restart mid-ring
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // Directed: smallest mesh (3 slices, 2 stacks), max radius, whole cycle
        write_reg(REG_RADIUS, 23'h7FFFFF);
        write_reg(REG_SLICES, 23'd3);
        write_reg(REG_STACKS, 23'd2);
        run_sequence(17, 0);
        drain();

        // Directed: out-of-range counts saturate, zero radius
        write_reg(REG_RADIUS, 23'd0);
        write_reg(REG_SLICES, 23'd0);
        write_reg(REG_STACKS, 23'd127);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // Random phases over settings and idle patterns
        for (int p = 0; p < 16; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            ns = (p == 5) ? 64 : $urandom_range(1, 6);
            nk = (p == 9) ? 64 : $urandom_range(0, 5);
            if (p == 13) begin
                ns = 127;
                nk = 1;
            end
            write_reg(REG_RADIUS, (p == 3) ? 23'h7FFFFF : 23'($urandom));
            write_reg(REG_SLICES, 23'(ns));
            write_reg(REG_STACKS, 23'(nk));
            seq = (p == 5 || p == 9) ? 60 : 62;
            run_sequence(seq, 3);
            drain();
        end

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
